// ----- src/cau_pkg.sv -----
package cau_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  typedef enum logic [2:0] {
    FN_ADD   = 3'd0,
    FN_MUL   = 3'd1,
    FN_CONJ  = 3'd2,
    FN_RECIP = 3'd3,
    FN_DIV   = 3'd4,
    FN_EQ    = 3'd5,
    FN_ABS   = 3'd6,
    FN_NE    = 3'd7
  } func_t;

endpackage

// ----- src/cau_iter_pipe.sv -----
module cau_iter_pipe #(
  parameter int W  = cau_pkg::DATA_WIDTH_DEF,
  parameter int TW = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [TW-1:0]      in_tag,
  input  logic [2*W-1:0]     in_den,
  input  logic [2*W-1:0]     in_xrem,
  input  logic [2*W-1:0]     in_yrem,
  input  logic [W-1:0]       in_xlo,
  input  logic [W-1:0]       in_ylo,
  output logic               out_valid,
  output logic [TW-1:0]      out_tag,
  output logic [W-1:0]       out_qx,
  output logic [W-1:0]       out_qy,
  output logic [W-1:0]       out_root
);

  // one quotient bit per stage for both dividers, one root bit per stage
  logic            vld_r [W];
  logic [TW-1:0]   tag_r [W];
  logic [2*W-1:0]  den_r [W];
  logic [2*W-1:0]  xr_r  [W];
  logic [2*W-1:0]  yr_r  [W];
  logic [W-1:0]    xl_r  [W];
  logic [W-1:0]    yl_r  [W];
  logic [W-1:0]    xq_r  [W];
  logic [W-1:0]    yq_r  [W];
  logic [2*W-1:0]  op_r  [W];
  logic [2*W-1:0]  rt_r  [W];

  for (genvar k = 0; k < W; k++) begin : g_stg
    logic            vld_i;
    logic [TW-1:0]   tag_i;
    logic [2*W-1:0]  den_i, xr_i, yr_i, op_i, rt_i;
    logic [W-1:0]    xl_i, yl_i, xq_i, yq_i;
    logic [2*W:0]    xt, yt, xd, yd, one, t;
    logic            xge, yge, sge;
    logic [2*W-1:0]  xr_nxt, yr_nxt, op_nxt, rt_nxt;
    logic [W-1:0]    xq_nxt, yq_nxt;

    if (k == 0) begin : g_first
      assign vld_i = in_valid;
      assign tag_i = in_tag;
      assign den_i = in_den;
      assign xr_i  = in_xrem;
      assign yr_i  = in_yrem;
      assign xl_i  = in_xlo;
      assign yl_i  = in_ylo;
      assign xq_i  = '0;
      assign yq_i  = '0;
      assign op_i  = in_den;
      assign rt_i  = '0;
    end else begin : g_next
      assign vld_i = vld_r[k-1];
      assign tag_i = tag_r[k-1];
      assign den_i = den_r[k-1];
      assign xr_i  = xr_r[k-1];
      assign yr_i  = yr_r[k-1];
      assign xl_i  = xl_r[k-1];
      assign yl_i  = yl_r[k-1];
      assign xq_i  = xq_r[k-1];
      assign yq_i  = yq_r[k-1];
      assign op_i  = op_r[k-1];
      assign rt_i  = rt_r[k-1];
    end

    always_comb begin
      xt     = {xr_i, xl_i[W-1]};
      yt     = {yr_i, yl_i[W-1]};
      xge    = xt >= {1'b0, den_i};
      yge    = yt >= {1'b0, den_i};
      xd     = xge ? (xt - {1'b0, den_i}) : xt;
      yd     = yge ? (yt - {1'b0, den_i}) : yt;
      xr_nxt = xd[2*W-1:0];
      yr_nxt = yd[2*W-1:0];
      xq_nxt = {xq_i[W-2:0], xge};
      yq_nxt = {yq_i[W-2:0], yge};
      one    = (2*W+1)'(1) << (2 * (W - 1 - k));
      t      = {1'b0, rt_i} + one;
      sge    = {1'b0, op_i} >= t;
      op_nxt = sge ? (op_i - t[2*W-1:0]) : op_i;
      rt_nxt = sge ? ((rt_i >> 1) + one[2*W-1:0]) : (rt_i >> 1);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_i;
      end
      tag_r[k] <= tag_i;
      den_r[k] <= den_i;
      xr_r[k]  <= xr_nxt;
      yr_r[k]  <= yr_nxt;
      xl_r[k]  <= xl_i << 1;
      yl_r[k]  <= yl_i << 1;
      xq_r[k]  <= xq_nxt;
      yq_r[k]  <= yq_nxt;
      op_r[k]  <= op_nxt;
      rt_r[k]  <= rt_nxt;
    end
  end

  assign out_valid = vld_r[W-1];
  assign out_tag   = tag_r[W-1];
  assign out_qx    = xq_r[W-1];
  assign out_qy    = yq_r[W-1];
  assign out_root  = rt_r[W-1][W-1:0];

endmodule

// ----- src/complex_arithmetic_unit.sv -----
// Complex fixed-point ALU, signed DATA_WIDTH bits with FRAC_BITS fraction.
// A word is taken on every cycle start is high; busy stays low, since the
// pipeline never holds. Each result is flagged by a one-cycle out_valid
// strobe and leaves in order; the depth is set by the bit-per-stage reciprocal
// divider and square root, which every operation passes through. The receiver
// cannot stall: results must be taken in the cycle they appear.
module complex_arithmetic_unit #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  cau_pkg::func_t               in_func,
  input  logic signed [DATA_WIDTH-1:0] in_a_re,
  input  logic signed [DATA_WIDTH-1:0] in_a_im,
  input  logic signed [DATA_WIDTH-1:0] in_b_re,
  input  logic signed [DATA_WIDTH-1:0] in_b_im,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] out_res_re,
  output logic signed [DATA_WIDTH-1:0] out_res_im,
  output logic                         out_compare_true,
  output logic                         out_div_zero,
  output logic                         out_saturated,
  output logic                         out_is_real,
  output logic                         out_is_imaginary
);

  import cau_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int NW = W + 2 * F;
  localparam int CW = ((NW > 2 * W) ? NW : 2 * W) + 1;
  localparam int SW = 2 * W + 2;
  localparam int TW = 3 + 4 * W + 5;

  localparam logic [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [SW-1:0] MAXS = $signed({{(SW-W+1){1'b0}}, {(W-1){1'b1}}});
  localparam logic signed [SW-1:0] MINS = $signed({{(SW-W+1){1'b1}}, {(W-1){1'b0}}});

  // {clip, value}
  function automatic logic [W:0] sat_fn(input logic signed [SW-1:0] v);
    logic [W:0] r;
    if (v > MAXS) r = {1'b1, MAXW};
    else if (v < MINS) r = {1'b1, MINW};
    else r = {1'b0, v[W-1:0]};
    return r;
  endfunction

  assign busy = 1'b0;

  // stage 0: input word
  logic                v0_r;
  func_t               f0_r;
  logic signed [W-1:0] are0_r, aim0_r, bre0_r, bim0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start;
    end
    f0_r   <= in_func;
    are0_r <= in_a_re;
    aim0_r <= in_a_im;
    bre0_r <= in_b_re;
    bim0_r <= in_b_im;
  end

  // stage 1: magnitudes and squares of the reciprocal operand
  logic [W-1:0]        x_s, y_s, xm_s, ym_s;
  logic                xn_s, yn_s;
  logic                v1_r, xn1_r, yn1_r;
  func_t               f1_r;
  logic signed [W-1:0] are1_r, aim1_r, bre1_r, bim1_r;
  logic [W-1:0]        xm1_r, ym1_r;
  logic [2*W-1:0]      sqx1_r, sqy1_r;

  always_comb begin
    x_s  = (f0_r == FN_DIV) ? bre0_r : are0_r;
    y_s  = (f0_r == FN_DIV) ? bim0_r : aim0_r;
    xn_s = x_s[W-1];
    yn_s = y_s[W-1];
    xm_s = xn_s ? (~x_s + 1'b1) : x_s;
    ym_s = yn_s ? (~y_s + 1'b1) : y_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
    f1_r   <= f0_r;
    are1_r <= are0_r;
    aim1_r <= aim0_r;
    bre1_r <= bre0_r;
    bim1_r <= bim0_r;
    xn1_r  <= xn_s;
    yn1_r  <= yn_s;
    xm1_r  <= xm_s;
    ym1_r  <= ym_s;
    sqx1_r <= (2*W)'(xm_s) * (2*W)'(xm_s);
    sqy1_r <= (2*W)'(ym_s) * (2*W)'(ym_s);
  end

  // stage 2: denominator, quotient range check, divider seeds
  logic [2*W-1:0] den_s;
  logic [NW-1:0]  nx_s, ny_s;
  logic [CW-1:0]  hix_s, hiy_s;
  logic           bx_s, by_s, dz_s;
  logic           v2_r;
  logic [TW-1:0]  tag2_r;
  logic [2*W-1:0] den2_r, xrem2_r, yrem2_r;
  logic [W-1:0]   xlo2_r, ylo2_r;

  always_comb begin
    den_s = sqx1_r + sqy1_r;
    nx_s  = NW'(xm1_r) << (2 * F);
    ny_s  = NW'(ym1_r) << (2 * F);
    hix_s = CW'(nx_s >> W);
    hiy_s = CW'(ny_s >> W);
    bx_s  = hix_s >= CW'(den_s);
    by_s  = hiy_s >= CW'(den_s);
    dz_s  = den_s == '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    tag2_r  <= {f1_r, are1_r, aim1_r, bre1_r, bim1_r, xn1_r, yn1_r, bx_s, by_s, dz_s};
    den2_r  <= den_s;
    xrem2_r <= hix_s[2*W-1:0];
    yrem2_r <= hiy_s[2*W-1:0];
    xlo2_r  <= nx_s[W-1:0];
    ylo2_r  <= ny_s[W-1:0];
  end

  logic           vs;
  logic [TW-1:0]  tags;
  logic [W-1:0]   qx, qy, root;

  cau_iter_pipe #(
    .W  (W),
    .TW (TW)
  ) u_iter (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v2_r),
    .in_tag    (tag2_r),
    .in_den    (den2_r),
    .in_xrem   (xrem2_r),
    .in_yrem   (yrem2_r),
    .in_xlo    (xlo2_r),
    .in_ylo    (ylo2_r),
    .out_valid (vs),
    .out_tag   (tags),
    .out_qx    (qx),
    .out_qy    (qy),
    .out_root  (root)
  );

  // stage 3: clip reciprocal and root
  logic [2:0]          t_f;
  logic signed [W-1:0] t_are, t_aim, t_bre, t_bim;
  logic                t_xn, t_yn, t_bx, t_by, t_dz;
  logic signed [SW-1:0] qxs_s, qys_s;
  logic [W:0]          sx_s, sy_s, sr_s;
  logic [W-1:0]        rr_s, ri_s;
  logic                rcx_s, rcy_s;

  assign {t_f, t_are, t_aim, t_bre, t_bim, t_xn, t_yn, t_bx, t_by, t_dz} = tags;

  always_comb begin
    qxs_s = $signed(SW'(qx));
    qys_s = $signed(SW'(qy));
    sx_s  = sat_fn(t_xn ? -qxs_s : qxs_s);
    sy_s  = sat_fn(t_yn ? qys_s : -qys_s);
    sr_s  = sat_fn($signed(SW'(root)));
    if (t_bx) begin
      rr_s  = t_xn ? MINW : MAXW;
      rcx_s = 1'b1;
    end else begin
      rr_s  = sx_s[W-1:0];
      rcx_s = sx_s[W];
    end
    if (t_by) begin
      ri_s  = t_yn ? MAXW : MINW;
      rcy_s = 1'b1;
    end else begin
      ri_s  = sy_s[W-1:0];
      rcy_s = sy_s[W];
    end
  end

  logic                v3_r, rclip3_r, absc3_r, dz3_r;
  func_t               f3_r;
  logic signed [W-1:0] are3_r, aim3_r, bre3_r, bim3_r, rr3_r, ri3_r;
  logic [W-1:0]        abs3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= vs;
    end
    f3_r     <= func_t'(t_f);
    are3_r   <= t_are;
    aim3_r   <= t_aim;
    bre3_r   <= t_bre;
    bim3_r   <= t_bim;
    rr3_r    <= rr_s;
    ri3_r    <= ri_s;
    rclip3_r <= rcx_s | rcy_s;
    abs3_r   <= sr_s[W-1:0];
    absc3_r  <= sr_s[W];
    dz3_r    <= t_dz;
  end

  // stage 4: cross products, add, negate, compare
  logic signed [W-1:0]   c_s, d_s;
  logic                  v4_r, rclip4_r, absc4_r, dz4_r, eq4_r;
  func_t                 f4_r;
  logic signed [W-1:0]   are4_r, rr4_r, ri4_r;
  logic [W-1:0]          abs4_r;
  logic signed [2*W-1:0] p1_r, p2_r, p3_r, p4_r;
  logic signed [W:0]     sre4_r, sim4_r, nim4_r;

  assign c_s = (f3_r == FN_DIV) ? rr3_r : bre3_r;
  assign d_s = (f3_r == FN_DIV) ? ri3_r : bim3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    f4_r     <= f3_r;
    are4_r   <= are3_r;
    rr4_r    <= rr3_r;
    ri4_r    <= ri3_r;
    rclip4_r <= rclip3_r;
    abs4_r   <= abs3_r;
    absc4_r  <= absc3_r;
    dz4_r    <= dz3_r;
    eq4_r    <= (are3_r == bre3_r) && (aim3_r == bim3_r);
    p1_r     <= (2*W)'(are3_r) * (2*W)'(c_s);
    p2_r     <= (2*W)'(aim3_r) * (2*W)'(d_s);
    p3_r     <= (2*W)'(are3_r) * (2*W)'(d_s);
    p4_r     <= (2*W)'(aim3_r) * (2*W)'(c_s);
    sre4_r   <= (W+1)'(are3_r) + (W+1)'(bre3_r);
    sim4_r   <= (W+1)'(aim3_r) + (W+1)'(bim3_r);
    nim4_r   <= -((W+1)'(aim3_r));
  end

  // stage 5: truncate, clip, select
  logic signed [SW-1:0] mre_s, mim_s;
  logic [W:0]           smr_s, smi_s, sar_s, sai_s, snc_s;
  logic [W-1:0]         re_s, im_s;
  logic                 cmp_s, dzo_s, clip_s;

  always_comb begin
    mre_s  = (SW'(p1_r) - SW'(p2_r)) >>> F;
    mim_s  = (SW'(p3_r) + SW'(p4_r)) >>> F;
    smr_s  = sat_fn(mre_s);
    smi_s  = sat_fn(mim_s);
    sar_s  = sat_fn(SW'(sre4_r));
    sai_s  = sat_fn(SW'(sim4_r));
    snc_s  = sat_fn(SW'(nim4_r));
    re_s   = '0;
    im_s   = '0;
    cmp_s  = 1'b0;
    dzo_s  = 1'b0;
    clip_s = 1'b0;
    unique case (f4_r)
      FN_ADD: begin
        re_s   = sar_s[W-1:0];
        im_s   = sai_s[W-1:0];
        clip_s = sar_s[W] | sai_s[W];
      end
      FN_MUL: begin
        re_s   = smr_s[W-1:0];
        im_s   = smi_s[W-1:0];
        clip_s = smr_s[W] | smi_s[W];
      end
      FN_CONJ: begin
        re_s   = are4_r;
        im_s   = snc_s[W-1:0];
        clip_s = snc_s[W];
      end
      FN_RECIP: begin
        re_s   = rr4_r;
        im_s   = ri4_r;
        clip_s = rclip4_r;
      end
      FN_DIV: begin
        re_s   = smr_s[W-1:0];
        im_s   = smi_s[W-1:0];
        clip_s = rclip4_r | smr_s[W] | smi_s[W];
      end
      FN_EQ: cmp_s = eq4_r;
      FN_ABS: begin
        re_s   = abs4_r;
        clip_s = absc4_r;
      end
      FN_NE: cmp_s = !eq4_r;
      default: cmp_s = 1'b0;
    endcase
    if (dz4_r && (f4_r == FN_RECIP || f4_r == FN_DIV)) begin
      re_s   = '0;
      im_s   = '0;
      clip_s = 1'b0;
      dzo_s  = 1'b1;
    end
  end

  logic         ov_r, ocmp_r, odz_r, oclip_r, oreal_r, oimag_r;
  logic [W-1:0] ore_r, oim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= v4_r;
    end
    ore_r   <= re_s;
    oim_r   <= im_s;
    ocmp_r  <= cmp_s;
    odz_r   <= dzo_s;
    oclip_r <= clip_s;
    oreal_r <= im_s == '0;
    oimag_r <= re_s == '0;
  end

  assign out_valid        = ov_r;
  assign out_res_re       = ore_r;
  assign out_res_im       = oim_r;
  assign out_compare_true = ocmp_r;
  assign out_div_zero     = odz_r;
  assign out_saturated    = oclip_r;
  assign out_is_real      = oreal_r;
  assign out_is_imaginary = oimag_r;

  a_dz_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_zero |-> out_res_re == '0 && out_res_im == '0 && !out_saturated)
    else $error("div_zero word carries data");

  a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_compare_true |-> out_is_real && out_is_imaginary && !out_div_zero)
    else $error("compare word not zero");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> ##(W+3) out_valid)
    else $error("word lost in pipeline");

endmodule

// ----- dv/complex_arithmetic_unit_tb.sv -----
`timescale 1ns / 1ps

module complex_arithmetic_unit_tb;
  import cau_pkg::*;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 60;

  typedef logic signed [DW-1:0] word_t;
  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    word_t re;
    word_t im;
    logic  cmp;
    logic  dz;
    logic  sat;
    logic  real_f;
    logic  imag_f;
  } cplx_result_t;

  logic clk, rst_n, start, busy;
  func_t in_func;
  word_t in_a_re, in_a_im, in_b_re, in_b_im;
  logic out_valid;
  word_t out_res_re, out_res_im;
  logic out_compare_true, out_div_zero, out_saturated, out_is_real, out_is_imaginary;

  cplx_result_t pending_results[$];
  int errors = 0;
  int words_sent = 0;
  int results_seen = 0;
  int stall_cnt = 0;
  int op_count[8];
  bit idle_en = 1;

  complex_arithmetic_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_a_re(in_a_re), .in_a_im(in_a_im),
    .in_b_re(in_b_re), .in_b_im(in_b_im),
    .out_valid(out_valid), .out_res_re(out_res_re), .out_res_im(out_res_im),
    .out_compare_true(out_compare_true), .out_div_zero(out_div_zero),
    .out_saturated(out_saturated), .out_is_real(out_is_real),
    .out_is_imaginary(out_is_imaginary)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic word_t clip_word(wide_t v, inout logic clip);
    wide_t hi, lo;
    hi = (wide_t'(1) <<< (DW-1)) - 1;
    lo = -(wide_t'(1) <<< (DW-1));
    if (v > hi) begin
      clip = 1;
      return hi[DW-1:0];
    end
    if (v < lo) begin
      clip = 1;
      return lo[DW-1:0];
    end
    return v[DW-1:0];
  endfunction

  function automatic void cplx_mul(word_t ar, word_t ai, word_t br, word_t bi,
                                   output word_t re, output word_t im, inout logic clip);
    wide_t xr, xi, yr, yi;
    xr = ar; xi = ai; yr = br; yi = bi;
    re = clip_word((xr*yr - xi*yi) >>> FB, clip);
    im = clip_word((xr*yi + xi*yr) >>> FB, clip);
  endfunction

  function automatic bit cplx_recip(word_t xr_w, word_t xi_w,
                                    output word_t re, output word_t im, inout logic clip);
    wide_t xr, xi, den;
    xr = xr_w; xi = xi_w;
    den = xr*xr + xi*xi;
    re = 0; im = 0;
    if (den == 0) return 0;
    re = clip_word((xr <<< (2*FB)) / den, clip);
    im = clip_word(-((xi <<< (2*FB)) / den), clip);
    return 1;
  endfunction

  function automatic cplx_result_t predict_result(func_t f, word_t ar, word_t ai,
                                                  word_t br, word_t bi);
    cplx_result_t r;
    logic clip;
    word_t rr, ri;
    wide_t xr, xi, sq, root, cand;
    bit eq;
    clip = 0;
    r = '0;
    eq = (ar == br) && (ai == bi);
    xr = ar; xi = ai;
    case (f)
      FN_ADD: begin
        r.re = clip_word(xr + wide_t'(br), clip);
        r.im = clip_word(xi + wide_t'(bi), clip);
      end
      FN_MUL: cplx_mul(ar, ai, br, bi, r.re, r.im, clip);
      FN_CONJ: begin
        r.re = ar;
        r.im = clip_word(-xi, clip);
      end
      FN_RECIP: r.dz = !cplx_recip(ar, ai, r.re, r.im, clip);
      FN_DIV: begin
        r.dz = !cplx_recip(br, bi, rr, ri, clip);
        if (!r.dz) cplx_mul(ar, ai, rr, ri, r.re, r.im, clip);
      end
      FN_EQ: r.cmp = eq;
      FN_ABS: begin
        sq = xr*xr + xi*xi;
        root = 0;
        for (int b = 63; b >= 0; b--) begin
          cand = root | (wide_t'(1) <<< b);
          if (cand*cand <= sq) root = cand;
        end
        r.re = clip_word(root, clip);
      end
      default: r.cmp = !eq;
    endcase
    if (r.dz) begin
      r.re = 0; r.im = 0; clip = 0;
    end
    r.sat = clip;
    r.real_f = (r.im == 0);
    r.imag_f = (r.re == 0);
    return r;
  endfunction

  // scoreboard
  always @(posedge clk) begin
    cplx_result_t e;
    if (rst_n && ((start && !busy) || out_valid)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected re=%h im=%h", $time,
                 out_res_re, out_res_im);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_res_re !== e.re) begin
          $display("%0t: res_re exp %h got %h", $time, e.re, out_res_re); errors++;
        end
        if (out_res_im !== e.im) begin
          $display("%0t: res_im exp %h got %h", $time, e.im, out_res_im); errors++;
        end
        if (out_compare_true !== e.cmp) begin
          $display("%0t: compare_true exp %b got %b", $time, e.cmp, out_compare_true);
          errors++;
        end
        if (out_div_zero !== e.dz) begin
          $display("%0t: div_zero exp %b got %b", $time, e.dz, out_div_zero); errors++;
        end
        if (out_saturated !== e.sat) begin
          $display("%0t: saturated exp %b got %b", $time, e.sat, out_saturated); errors++;
        end
        if (out_is_real !== e.real_f) begin
          $display("%0t: is_real exp %b got %b", $time, e.real_f, out_is_real); errors++;
        end
        if (out_is_imaginary !== e.imag_f) begin
          $display("%0t: is_imaginary exp %b got %b", $time, e.imag_f, out_is_imaginary);
          errors++;
        end
      end
    end
  end

  initial begin
    wait (stall_cnt >= WATCHDOG_LIMIT);
    $display("%0t: watchdog expired", $time);
    $display("end of test: mismatches");
    $finish;
  end

  task automatic send_word(func_t f, word_t ar, word_t ai, word_t br, word_t bi);
    while (idle_en && $urandom_range(99) < 31) begin
      start <= 0;
      @(negedge clk);
    end
    start <= 1;
    in_func <= f;
    in_a_re <= ar; in_a_im <= ai; in_b_re <= br; in_b_im <= bi;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_result(f, ar, ai, br, bi));
    words_sent++;
    op_count[f]++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    start <= 0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic word_t rand_operand();
    case ($urandom_range(9))
      0: return {1'b1, {(DW-1){1'b0}}};
      1: return {1'b0, {(DW-1){1'b1}}};
      2: return 0;
      3: return word_t'($urandom_range(3)) - 1;
      4, 5: return word_t'($signed($urandom_range(1 << 20))) - (1 << 19);
      6: return word_t'($signed($urandom_range(1 << 26))) - (1 << 25);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    word_t mn, mx;
    mn = {1'b1, {(DW-1){1'b0}}};
    mx = {1'b0, {(DW-1){1'b1}}};
    send_word(FN_ADD, mx, mn, mx, mn);
    send_word(FN_ADD, 32'h0001_8000, -32'sh0000_4000, 32'h0000_8000, 32'h0000_4000);
    send_word(FN_MUL, mn, mn, mn, mn);
    send_word(FN_MUL, mx, mn, mx, mx);
    send_word(FN_MUL, 32'h0002_0000, 32'h0001_0000, 32'h0000_8000, -32'sh0003_0000);
    send_word(FN_CONJ, mn, mn, 0, 0);
    send_word(FN_CONJ, mx, mx, 0, 0);
    send_word(FN_RECIP, 0, 0, 5, 7);
    send_word(FN_RECIP, 1, 0, 0, 0);
    send_word(FN_RECIP, mn, 0, 0, 0);
    send_word(FN_RECIP, 32'h0002_0000, -32'sh0002_0000, 0, 0);
    send_word(FN_DIV, 32'h0001_0000, 32'h0001_0000, 0, 0);
    send_word(FN_DIV, mx, mn, 1, 0);
    send_word(FN_DIV, 32'h0003_0000, 32'h0004_0000, 32'h0001_0000, -32'sh0002_0000);
    send_word(FN_DIV, mn, mx, mn, mn);
    send_word(FN_EQ, mn, mx, mn, mx);
    send_word(FN_EQ, mn, mx, mn, mn);
    send_word(FN_NE, 5, 6, 5, 6);
    send_word(FN_NE, 5, 6, 5, 7);
    send_word(FN_ABS, mn, mn, 0, 0);
    send_word(FN_ABS, 32'h0003_0000, -32'sh0004_0000, 0, 0);
    send_word(FN_ABS, 0, 0, mx, mx);
    wait_drained();
  endtask

  task automatic test_random(int n);
    func_t f;
    word_t ar, ai, br, bi;
    for (int i = 0; i < n; i++) begin
      f = func_t'($urandom_range(7));
      ar = rand_operand(); ai = rand_operand();
      br = rand_operand(); bi = rand_operand();
      if ((f == FN_EQ || f == FN_NE) && $urandom_range(1)) begin
        br = ar; bi = ai;
        if ($urandom_range(2) == 0) bi = bi ^ (word_t'(1) << $urandom_range(DW-1));
      end
      send_word(f, ar, ai, br, bi);
    end
  endtask

  task automatic test_back_to_back(int n);
    idle_en = 0;
    test_random(n);
    idle_en = 1;
  endtask

  task automatic test_pause_until_drained();
    test_random(40);
    wait_drained();
    test_random(40);
  endtask

  initial begin
    rst_n = 0;
    start = 0;
    in_func = FN_ADD;
    in_a_re = 0; in_a_im = 0; in_b_re = 0; in_b_im = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    @(negedge clk);
    test_directed();
    test_random(800);
    test_back_to_back(300);
    test_pause_until_drained();
    test_random(570);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d words sent, %0d results checked; ops add..ne: %0d %0d %0d %0d %0d %0d %0d %0d",
             words_sent, results_seen, op_count[0], op_count[1], op_count[2], op_count[3],
             op_count[4], op_count[5], op_count[6], op_count[7]);
    $display("idle gaps, a back-to-back stretch and a full drain pause were covered");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
